// ===== hw/rtl/multi_pattern_match_counter_unit_assert.svh =====
`ifndef MULTI_PATTERN_MATCH_COUNTER_UNIT_ASSERT_SVH
`define MULTI_PATTERN_MATCH_COUNTER_UNIT_ASSERT_SVH

// same-cycle implication
`define MPMC_ASSERT_NOW(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("mpmc assertion failed");

// next-cycle implication
`define MPMC_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("mpmc assertion failed");

`endif

// ===== hw/rtl/mpmc_pkg.sv =====
package mpmc_pkg;

	localparam int MAX_NODES    = 4096;
	localparam int ALPHABET     = 26;
	localparam int MAX_PATTERNS = 1024;
	localparam int COUNT_BITS   = 32;

	localparam int NODE_W      = $clog2(MAX_NODES);
	localparam int SYM_W       = 5;
	localparam int PAT_W       = $clog2(MAX_PATTERNS);
	localparam int PCNT_W      = PAT_W + 1;
	localparam int QPTR_W      = NODE_W + 1;
	localparam int CHILD_DEPTH = MAX_NODES * ALPHABET;
	localparam int CHILD_AW    = $clog2(CHILD_DEPTH);

	localparam logic [2:0] CMD_ADD    = 3'd0;
	localparam logic [2:0] CMD_BUILD  = 3'd1;
	localparam logic [2:0] CMD_SCAN   = 3'd2;
	localparam logic [2:0] CMD_READ   = 3'd3;
	localparam logic [2:0] CMD_CLEAR  = 3'd4;
	localparam logic [2:0] CMD_RSVD_5 = 3'd5;
	localparam logic [2:0] CMD_RSVD_6 = 3'd6;
	localparam logic [2:0] CMD_RSVD_7 = 3'd7;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_TRIE_FULL = 2'd1;
	localparam logic [1:0] ST_PAT_FULL  = 2'd2;
	localparam logic [1:0] ST_BAD       = 2'd3;

	typedef struct packed {
		logic [2:0]  command;
		logic [4:0]  symbol;
		logic        last_symbol;
		logic [9:0]  pattern_id;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] match_count;
		logic [9:0]  assigned_id;
	} rsp_t;

endpackage

// ===== hw/rtl/mpmc_ram.sv =====
module mpmc_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hw/rtl/multi_pattern_match_counter_unit.sv =====
// channel | direction | handshake           | word
// cmd     | in        | cmd_valid/cmd_stall | cmd_word (cmd_t)
// rsp     | out       | rsp_valid/rsp_stall | rsp_word (rsp_t)
//
// One word at a time over a single-port child table; cmd_stall is high until
// the result is registered. Add clears the new node's child row when a node
// is made. Build visits the nodes in breadth-first order, letter by letter.
// Scan walks the failure chain. Clear and reset: a clearing pass of the root
// row. A stalled rsp holds its word; the next cmd is taken meanwhile.
module multi_pattern_match_counter_unit import mpmc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_t cmd_word,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp_word
);

	typedef enum logic [4:0] {
		S_CLR, S_IDLE, S_DISP, S_A_CHK, S_A_CLR, S_A_FIN,
		S_B_NODE, S_B_U, S_B_FU, S_B_RDUV, S_B_RDFU, S_B_WR,
		S_S_FIRST, S_S_LOOP, S_S_UPD, S_R_N, S_R_C, S_FIN
	} state_t;

	state_t state_q;
	cmd_t cmd_q;
	logic clr_rsp_q, built_q, rsp_valid_q;
	logic [NODE_W-1:0] node_count_q, cursor_q, scan_q, next_q, u_q, fu_q, v_q, t_q;
	logic [PCNT_W-1:0] pat_count_q;
	logic [QPTR_W-1:0] head_q, tail_q, steps_q;
	logic [SYM_W-1:0] idx_q;
	logic [1:0] st_q;
	logic [31:0] cnt_q;
	logic [9:0] aid_q;
	rsp_t rsp_q;

	logic [NODE_W-1:0] ch_node;
	logic [SYM_W-1:0] ch_sym;
	logic [CHILD_AW-1:0] ch_addr;
	logic ch_we, fl_we, hit_we, q_we, pe_we;
	logic [NODE_W-1:0] ch_wdata, ch_rdata, fl_waddr, fl_wdata, fl_raddr, fl_rdata;
	logic [NODE_W-1:0] hit_waddr, hit_raddr, q_wdata, q_rdata, pe_rdata;
	logic [COUNT_BITS-1:0] hit_wdata, hit_rdata;
	logic [NODE_W-1:0] q_waddr, q_raddr;
	logic last_sym;

	assign last_sym = (idx_q == SYM_W'(ALPHABET - 1));
	assign ch_addr  = CHILD_AW'(CHILD_AW'(ch_node) * CHILD_AW'(ALPHABET)) + CHILD_AW'(ch_sym);

	always_comb begin
		ch_node   = u_q;
		ch_sym    = idx_q;
		ch_we     = 1'b0;
		ch_wdata  = '0;
		fl_we     = 1'b0;
		fl_waddr  = v_q;
		fl_wdata  = '0;
		fl_raddr  = t_q;
		hit_we    = 1'b0;
		hit_waddr = t_q;
		hit_wdata = (hit_rdata == '1) ? hit_rdata : hit_rdata + 1'b1;
		hit_raddr = t_q;
		q_we      = 1'b0;
		q_waddr   = tail_q[NODE_W-1:0];
		q_wdata   = v_q;
		q_raddr   = head_q[NODE_W-1:0];
		pe_we     = 1'b0;
		unique case (state_q)
			S_CLR: begin
				ch_node  = '0;
				ch_we    = 1'b1;
				fl_we    = (idx_q == '0);
				fl_waddr = '0;
			end
			S_DISP: begin
				ch_node = (cmd_q.command == CMD_SCAN) ? scan_q : cursor_q;
				ch_sym  = cmd_q.symbol;
				q_we    = (cmd_q.command == CMD_BUILD) && !built_q;
				q_waddr = '0;
				q_wdata = '0;
			end
			S_A_CHK: begin
				ch_node  = cursor_q;
				ch_sym   = cmd_q.symbol;
				ch_we    = (ch_rdata == '0) &&
					((QPTR_W'(node_count_q) + 1'b1) < QPTR_W'(MAX_NODES));
				ch_wdata = node_count_q + 1'b1;
			end
			S_A_CLR: begin
				ch_node   = node_count_q;
				ch_we     = 1'b1;
				hit_we    = (idx_q == '0);
				hit_waddr = node_count_q;
				hit_wdata = '0;
			end
			S_A_FIN: begin
				pe_we = cmd_q.last_symbol;
			end
			S_B_U: begin
				fl_raddr = q_rdata;
			end
			S_B_RDFU: begin
				ch_node = fu_q;
			end
			S_B_WR: begin
				ch_we    = (v_q == '0);
				ch_wdata = ch_rdata;
				fl_we    = (v_q != '0);
				fl_wdata = (u_q == '0) ? '0 : ch_rdata;
				q_we     = (v_q != '0) && (tail_q < QPTR_W'(MAX_NODES));
			end
			S_S_UPD: begin
				hit_we = 1'b1;
			end
			S_R_N: begin
				hit_raddr = pe_rdata;
			end
			default: begin
			end
		endcase
	end

	mpmc_ram #(.DEPTH(CHILD_DEPTH), .WIDTH(NODE_W)) u_child (
		.clk, .we(ch_we), .waddr(ch_addr), .wdata(ch_wdata), .raddr(ch_addr), .rdata(ch_rdata)
	);
	mpmc_ram #(.DEPTH(MAX_NODES), .WIDTH(NODE_W)) u_fail (
		.clk, .we(fl_we), .waddr(fl_waddr), .wdata(fl_wdata), .raddr(fl_raddr), .rdata(fl_rdata)
	);
	mpmc_ram #(.DEPTH(MAX_NODES), .WIDTH(COUNT_BITS)) u_hits (
		.clk, .we(hit_we), .waddr(hit_waddr), .wdata(hit_wdata), .raddr(hit_raddr),
		.rdata(hit_rdata)
	);
	mpmc_ram #(.DEPTH(MAX_NODES), .WIDTH(NODE_W)) u_queue (
		.clk, .we(q_we), .waddr(q_waddr), .wdata(q_wdata), .raddr(q_raddr), .rdata(q_rdata)
	);
	mpmc_ram #(.DEPTH(MAX_PATTERNS), .WIDTH(NODE_W)) u_pend (
		.clk, .we(pe_we), .waddr(pat_count_q[PAT_W-1:0]), .wdata(next_q),
		.raddr(cmd_q.pattern_id[PAT_W-1:0]), .rdata(pe_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;
			cmd_q        <= '0;
			st_q         <= ST_OK;
			cnt_q        <= '0;
			aid_q        <= '0;
			rsp_q        <= '0;
			next_q       <= '0;
			u_q          <= '0;
			fu_q         <= '0;
			v_q          <= '0;
			t_q          <= '0;
			clr_rsp_q    <= 1'b0;
			built_q      <= 1'b0;
			rsp_valid_q  <= 1'b0;
			node_count_q <= '0;
			cursor_q     <= '0;
			scan_q       <= '0;
			pat_count_q  <= '0;
			idx_q        <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			steps_q      <= '0;
		end else begin
			if (rsp_valid_q && !rsp_stall && state_q != S_FIN) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					idx_q <= idx_q + 1'b1;
					if (last_sym) begin
						state_q <= clr_rsp_q ? S_FIN : S_IDLE;
					end
				end
				S_IDLE: begin
					if (cmd_valid) begin
						cmd_q   <= cmd_word;
						st_q    <= ST_OK;
						cnt_q   <= '0;
						aid_q   <= '0;
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					state_q <= S_FIN;
					unique case (cmd_q.command)
						CMD_ADD: begin
							if (built_q || cmd_q.symbol >= SYM_W'(ALPHABET)) begin
								st_q <= ST_BAD;
							end else if (cmd_q.last_symbol &&
								pat_count_q >= PCNT_W'(MAX_PATTERNS)) begin
								st_q <= ST_PAT_FULL;
							end else begin
								state_q <= S_A_CHK;
							end
						end
						CMD_BUILD: begin
							if (built_q) begin
								st_q <= ST_BAD;
							end else begin
								head_q  <= '0;
								tail_q  <= QPTR_W'(1);
								state_q <= S_B_NODE;
							end
						end
						CMD_SCAN: begin
							if (!built_q || cmd_q.symbol >= SYM_W'(ALPHABET)) begin
								st_q <= ST_BAD;
							end else begin
								state_q <= S_S_FIRST;
							end
						end
						CMD_READ: begin
							if (PCNT_W'(cmd_q.pattern_id) >= pat_count_q) begin
								st_q <= ST_BAD;
							end else begin
								state_q <= S_R_N;
							end
						end
						CMD_CLEAR: begin
							built_q      <= 1'b0;
							node_count_q <= '0;
							cursor_q     <= '0;
							scan_q       <= '0;
							pat_count_q  <= '0;
							idx_q        <= '0;
							clr_rsp_q    <= 1'b1;
							state_q      <= S_CLR;
						end
						default: begin
							st_q <= ST_BAD;
						end
					endcase
				end
				S_A_CHK: begin
					if (ch_rdata != '0) begin
						next_q  <= ch_rdata;
						state_q <= S_A_FIN;
					end else if ((QPTR_W'(node_count_q) + 1'b1) >= QPTR_W'(MAX_NODES)) begin
						st_q    <= ST_TRIE_FULL;
						state_q <= S_FIN;
					end else begin
						node_count_q <= node_count_q + 1'b1;
						next_q       <= node_count_q + 1'b1;
						idx_q        <= '0;
						state_q      <= S_A_CLR;
					end
				end
				S_A_CLR: begin
					idx_q <= idx_q + 1'b1;
					if (last_sym) begin
						state_q <= S_A_FIN;
					end
				end
				S_A_FIN: begin
					if (cmd_q.last_symbol) begin
						aid_q       <= pat_count_q[PAT_W-1:0];
						pat_count_q <= pat_count_q + 1'b1;
						cursor_q    <= '0;
					end else begin
						cursor_q <= next_q;
					end
					state_q <= S_FIN;
				end
				S_B_NODE: begin
					if (head_q < tail_q) begin
						head_q  <= head_q + 1'b1;
						state_q <= S_B_U;
					end else begin
						built_q <= 1'b1;
						state_q <= S_FIN;
					end
				end
				S_B_U: begin
					u_q     <= q_rdata;
					state_q <= S_B_FU;
				end
				S_B_FU: begin
					fu_q    <= fl_rdata;
					idx_q   <= '0;
					state_q <= S_B_RDUV;
				end
				S_B_RDUV: begin
					state_q <= S_B_RDFU;
				end
				S_B_RDFU: begin
					v_q     <= ch_rdata;
					state_q <= S_B_WR;
				end
				S_B_WR: begin
					if ((v_q != '0) && (tail_q < QPTR_W'(MAX_NODES))) begin
						tail_q <= tail_q + 1'b1;
					end
					idx_q   <= idx_q + 1'b1;
					state_q <= last_sym ? S_B_NODE : S_B_RDUV;
				end
				S_S_FIRST: begin
					scan_q  <= ch_rdata;
					t_q     <= ch_rdata;
					steps_q <= '0;
					state_q <= S_S_LOOP;
				end
				S_S_LOOP: begin
					if (t_q == '0 || steps_q >= QPTR_W'(MAX_NODES)) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_S_UPD;
					end
				end
				S_S_UPD: begin
					t_q     <= fl_rdata;
					steps_q <= steps_q + 1'b1;
					state_q <= S_S_LOOP;
				end
				S_R_N: begin
					state_q <= S_R_C;
				end
				S_R_C: begin
					cnt_q   <= 32'(hit_rdata);
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q.status      <= st_q;
						rsp_q.match_count <= cnt_q;
						rsp_q.assigned_id <= aid_q;
						rsp_valid_q       <= 1'b1;
						clr_rsp_q         <= 1'b0;
						state_q           <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign cmd_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_q;

endmodule

// ===== hw/rtl/mpmc_checker.sv =====
`include "multi_pattern_match_counter_unit_assert.svh"

module mpmc_checker import mpmc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input logic cmd_stall,
	input cmd_t cmd_word,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp_word
);

	logic cmd_fire;

	assign cmd_fire = cmd_valid && !cmd_stall;

	`MPMC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word))
	`MPMC_ASSERT_NEXT(a_busy_after_cmd, cmd_fire, cmd_stall)
	`MPMC_ASSERT_NOW(a_err_no_count, rsp_valid && rsp_word.status != ST_OK, rsp_word.match_count == '0)
	`MPMC_ASSERT_NOW(a_err_no_id, rsp_valid && rsp_word.status != ST_OK, rsp_word.assigned_id == '0)

endmodule

bind multi_pattern_match_counter_unit mpmc_checker u_mpmc_checker (.*);

// ===== tb/multi_pattern_match_counter_unit_tb.sv =====
`timescale 1ns / 100ps

module multi_pattern_match_counter_unit_tb;
	import mpmc_pkg::*;

	localparam int CYCLE_LIMIT = 4000000;

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cmd_t cmd_word;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp_word;

	multi_pattern_match_counter_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd_word(cmd_word),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_word(rsp_word)
	);

	// automaton mirror
	logic [NODE_W-1:0] trie_child [MAX_NODES*ALPHABET];
	logic [NODE_W-1:0] fail_link [MAX_NODES];
	logic [COUNT_BITS-1:0] hit_count [MAX_NODES];
	logic [NODE_W-1:0] pattern_node [MAX_PATTERNS];
	logic [NODE_W-1:0] bfs_order [MAX_NODES];
	int node_total;
	int insert_at;
	int pattern_total;
	int scan_at;
	bit links_built;

	rsp_t expected_rsp_q [$];
	int errors;
	int words_sent;
	int cycles;
	int sender_idle_pct;
	int receiver_idle_pct;
	int hold_left;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic void clear_automaton();
		foreach (trie_child[i]) trie_child[i] = '0;
		foreach (fail_link[i]) fail_link[i] = '0;
		foreach (hit_count[i]) hit_count[i] = '0;
		node_total = 0;
		insert_at = 0;
		pattern_total = 0;
		scan_at = 0;
		links_built = 0;
	endfunction

	function automatic void build_fail_links();
		int head;
		int tail;
		int u;
		int v;
		head = 0;
		tail = 1;
		bfs_order[0] = '0;
		while (head < tail) begin
			u = int'(bfs_order[head]);
			head++;
			for (int c = 0; c < ALPHABET; c++) begin
				v = int'(trie_child[u*ALPHABET+c]);
				if (v != 0) begin
					if (tail < MAX_NODES) begin
						bfs_order[tail] = NODE_W'(v);
						tail++;
					end
					fail_link[v] = (u == 0) ? '0 : trie_child[fail_link[u]*ALPHABET+c];
				end else begin
					trie_child[u*ALPHABET+c] = trie_child[fail_link[u]*ALPHABET+c];
				end
			end
		end
		links_built = 1;
	endfunction

	function automatic rsp_t predict_response(input cmd_t w);
		rsp_t r;
		int nxt;
		int t;
		int steps;
		r = '0;
		case (w.command)
			CMD_ADD: begin
				if (links_built || w.symbol >= ALPHABET) begin
					r.status = ST_BAD;
				end else if (w.last_symbol && pattern_total >= MAX_PATTERNS) begin
					r.status = ST_PAT_FULL;
				end else begin
					nxt = int'(trie_child[insert_at*ALPHABET+w.symbol]);
					if (nxt == 0 && node_total + 1 >= MAX_NODES) begin
						r.status = ST_TRIE_FULL;
					end else begin
						if (nxt == 0) begin
							node_total++;
							nxt = node_total;
							trie_child[insert_at*ALPHABET+w.symbol] = NODE_W'(nxt);
						end
						if (w.last_symbol) begin
							pattern_node[pattern_total] = NODE_W'(nxt);
							r.assigned_id = PAT_W'(pattern_total);
							pattern_total++;
							insert_at = 0;
						end else begin
							insert_at = nxt;
						end
					end
				end
			end
			CMD_BUILD: begin
				if (links_built) r.status = ST_BAD;
				else build_fail_links();
			end
			CMD_SCAN: begin
				if (!links_built || w.symbol >= ALPHABET) begin
					r.status = ST_BAD;
				end else begin
					scan_at = int'(trie_child[scan_at*ALPHABET+w.symbol]);
					t = scan_at;
					steps = 0;
					while (t != 0 && steps < MAX_NODES) begin
						if (hit_count[t] != '1) hit_count[t] = hit_count[t] + 1;
						t = int'(fail_link[t]);
						steps++;
					end
				end
			end
			CMD_READ: begin
				if (w.pattern_id >= pattern_total) r.status = ST_BAD;
				else r.match_count = hit_count[pattern_node[w.pattern_id]];
			end
			CMD_CLEAR: clear_automaton();
			default: r.status = ST_BAD;
		endcase
		return r;
	endfunction

	always @(posedge clk) begin
		rsp_t want;
		if (rsp_valid && !rsp_stall) begin
			if (expected_rsp_q.size() == 0) begin
				$display("unexpected response word at %0t", $realtime);
				errors++;
			end else begin
				want = expected_rsp_q.pop_front();
				if (rsp_word.status !== want.status)
					report_mismatch("status", rsp_word.status, want.status);
				if (rsp_word.match_count !== want.match_count)
					report_mismatch("match_count", rsp_word.match_count, want.match_count);
				if (rsp_word.assigned_id !== want.assigned_id)
					report_mismatch("assigned_id", rsp_word.assigned_id, want.assigned_id);
			end
		end
	end

	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
		end
	end

	function automatic cmd_t make_word(input logic [2:0] cmd, input int sym, input bit last,
			input int id);
		cmd_t w;
		w.command = cmd;
		w.symbol = 5'(sym);
		w.last_symbol = last;
		w.pattern_id = 10'(id);
		return w;
	endfunction

	task automatic send_word(input cmd_t w);
		if ($urandom_range(0, 99) < sender_idle_pct) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_word <= w;
		do @(posedge clk); while (cmd_stall);
		expected_rsp_q = {expected_rsp_q, predict_response(w)};
		words_sent++;
	endtask

	task automatic drain();
		cmd_valid <= 1'b0;
		while (expected_rsp_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic send_noise();
		send_word(make_word(3'($urandom_range(0, 7)), $urandom_range(0, 31),
			1'($urandom_range(0, 1)), $urandom_range(0, 1023)));
	endtask

	task automatic test_directed();
		send_word(make_word(CMD_SCAN, 0, 0, 0));
		send_word(make_word(CMD_RSVD_5, 0, 0, 0));
		send_word(make_word(CMD_RSVD_6, 31, 1, 1023));
		send_word(make_word(CMD_RSVD_7, 0, 0, 0));
		send_word(make_word(CMD_ADD, 26, 1, 0));
		send_word(make_word(CMD_ADD, 0, 0, 0));
		send_word(make_word(CMD_ADD, 1, 1, 0));
		send_word(make_word(CMD_ADD, 1, 0, 0));
		send_word(make_word(CMD_ADD, 25, 1, 0));
		send_word(make_word(CMD_ADD, 2, 0, 0));
		send_word(make_word(CMD_READ, 0, 0, 1));
		send_word(make_word(CMD_READ, 0, 0, 2));
		send_word(make_word(CMD_READ, 0, 0, 1023));
		send_word(make_word(CMD_BUILD, 0, 0, 0));
		send_word(make_word(CMD_BUILD, 0, 0, 0));
		send_word(make_word(CMD_ADD, 0, 1, 0));
		send_word(make_word(CMD_SCAN, 31, 0, 0));
		send_word(make_word(CMD_SCAN, 0, 0, 0));
		send_word(make_word(CMD_SCAN, 1, 0, 0));
		send_word(make_word(CMD_SCAN, 25, 0, 0));
		send_word(make_word(CMD_READ, 0, 1, 0));
		send_word(make_word(CMD_READ, 31, 0, 1));
		send_word(make_word(CMD_CLEAR, 0, 0, 0));
		send_word(make_word(CMD_READ, 0, 0, 0));
		drain();
	endtask

	task automatic run_sequence();
		int top_sym;
		top_sym = ($urandom_range(0, 3) == 0) ? ALPHABET - 1 : 3;
		send_word(make_word(CMD_CLEAR, 0, 0, 0));
		repeat ($urandom_range(2, 5)) begin
			int len;
			len = $urandom_range(1, 4);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 9) == 0) send_noise();
				send_word(make_word(CMD_ADD, $urandom_range(0, top_sym), i == len - 1,
					$urandom_range(0, 1023)));
			end
		end
		send_word(make_word(CMD_BUILD, 0, 0, 0));
		repeat ($urandom_range(10, 25)) begin
			if ($urandom_range(0, 9) == 0) send_noise();
			if ($urandom_range(0, 4) == 0)
				send_word(make_word(CMD_READ, $urandom_range(0, 31),
					1'($urandom_range(0, 1)), $urandom_range(0, pattern_total)));
			else
				send_word(make_word(CMD_SCAN, $urandom_range(0, top_sym), 0, 0));
		end
		for (int i = 0; i <= pattern_total; i++) send_word(make_word(CMD_READ, 0, 0, i));
	endtask

	task automatic test_random(input int count);
		int target;
		target = words_sent + count;
		while (words_sent < target) run_sequence();
		drain();
	endtask

	task automatic test_backpressure();
		hold_left = 400;
		run_sequence();
		drain();
		hold_left = 300;
		repeat (3) run_sequence();
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd_word = '0;
		rsp_stall = 1'b0;
		errors = 0;
		words_sent = 0;
		cycles = 0;
		hold_left = 0;
		sender_idle_pct = 15;
		receiver_idle_pct = 51;
		clear_automaton();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(70);
		sender_idle_pct = 51;
		receiver_idle_pct = 15;
		test_backpressure();
		test_random(70);
		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		test_random(70);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
